FILE: rtl/usw_pkg.sv
// ----------------------------------------------------------------------------
// usw_pkg: shared definitions for the link stall watchdog
// Register indexes, reset values, phase codes and the settings bundle.
// ----------------------------------------------------------------------------
package usw_pkg;

   localparam int unsigned REG_W  = 16;
   localparam int unsigned ADDR_W = 4;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_STUCK_LIMIT  = 2'd0;
   localparam logic [1:0] REG_OFF_TIME     = 2'd1;
   localparam logic [1:0] REG_HOST_WAIT    = 2'd2;
   localparam logic [1:0] REG_MIN_INTERVAL = 2'd3;

   localparam logic [REG_W-1:0] STUCK_LIMIT_DEFAULT  = 16'd1500;
   localparam logic [REG_W-1:0] OFF_TIME_DEFAULT     = 16'd500;
   localparam logic [REG_W-1:0] HOST_WAIT_DEFAULT    = 16'd5000;
   localparam logic [REG_W-1:0] MIN_INTERVAL_DEFAULT = 16'd10000;

   localparam logic [1:0] PHASE_WATCH = 2'd0;
   localparam logic [1:0] PHASE_OFF   = 2'd1;
   localparam logic [1:0] PHASE_WAIT  = 2'd2;

   typedef struct packed {
      logic [REG_W-1:0] stuck_limit_ms;
      logic [REG_W-1:0] off_time_ms;
      logic [REG_W-1:0] host_wait_ms;
      logic [REG_W-1:0] min_interval_ms;
   } usw_cfg_type;

endpackage

FILE: rtl/usw_csr.sv
// ----------------------------------------------------------------------------
// usw_csr: configuration registers
// APB-style write and read access to the four timing settings.
// ----------------------------------------------------------------------------
module usw_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [usw_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output usw_pkg::usw_cfg_type        cfg
);

   usw_pkg::usw_cfg_type cfg_ff, cfg_in;
   logic                 wr_en;
   logic [1:0]           reg_idx;
   logic [usw_pkg::REG_W-1:0] rd_val;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            usw_pkg::REG_STUCK_LIMIT:  cfg_in.stuck_limit_ms  = pwdata[15:0];
            usw_pkg::REG_OFF_TIME:     cfg_in.off_time_ms     = pwdata[15:0];
            usw_pkg::REG_HOST_WAIT:    cfg_in.host_wait_ms    = pwdata[15:0];
            usw_pkg::REG_MIN_INTERVAL: cfg_in.min_interval_ms = pwdata[15:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stuck_limit_ms  <= usw_pkg::STUCK_LIMIT_DEFAULT;
         cfg_ff.off_time_ms     <= usw_pkg::OFF_TIME_DEFAULT;
         cfg_ff.host_wait_ms    <= usw_pkg::HOST_WAIT_DEFAULT;
         cfg_ff.min_interval_ms <= usw_pkg::MIN_INTERVAL_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         usw_pkg::REG_STUCK_LIMIT:  rd_val = cfg_ff.stuck_limit_ms;
         usw_pkg::REG_OFF_TIME:     rd_val = cfg_ff.off_time_ms;
         usw_pkg::REG_HOST_WAIT:    rd_val = cfg_ff.host_wait_ms;
         usw_pkg::REG_MIN_INTERVAL: rd_val = cfg_ff.min_interval_ms;
         default:                   rd_val = '0;
      endcase
   end

   assign prdata = {16'd0, rd_val};
   assign cfg    = cfg_ff;

endmodule

FILE: rtl/usw_engine.sv
// ----------------------------------------------------------------------------
// usw_engine: watchdog state and decision logic
// Evaluates one poll from the input register and commits the new state
// when the beat moves on to the result register.
// ----------------------------------------------------------------------------
module usw_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  usw_pkg::usw_cfg_type        cfg,
   input  logic                        commit,
   input  logic [31:0]                 now_ms,
   input  logic                        link_awake,
   input  logic                        port_open,
   input  logic                        serial_busy,
   input  logic                        hid_busy,
   input  logic                        data_waiting,
   input  logic [31:0]                 bytes_taken,
   input  logic [31:0]                 config_count,
   input  logic                        reconnect_request,
   output logic                        do_disconnect,
   output logic                        do_connect,
   output logic [1:0]                  phase_now,
   output logic [31:0]                 reconnect_total
);

   logic [1:0]  phase_ff, phase_in;
   logic [31:0] phase_start_ff, phase_start_in;
   logic        serial_held_ff, serial_held_in;
   logic        hid_held_ff, hid_held_in;
   logic        data_held_ff, data_held_in;
   logic [31:0] serial_since_ff, serial_since_in;
   logic [31:0] hid_since_ff, hid_since_in;
   logic [31:0] data_since_ff, data_since_in;
   logic [31:0] last_bytes_ff;
   logic [31:0] reconnects_ff, reconnects_in;
   logic [31:0] last_rc_time_ff, last_rc_time_in;
   logic [31:0] cfg_at_rc_ff, cfg_at_rc_in;
   logic        req_pend_ff, req_pend_in;

   logic        pend, moved;
   logic        s_hold, h_hold, d_hold;
   logic [31:0] s_time, h_time, d_time;
   logic [31:0] phase_age, rc_age;
   logic        any_stuck, too_soon, go;

   assign pend      = req_pend_ff | reconnect_request;
   assign moved     = bytes_taken != last_bytes_ff;
   assign phase_age = now_ms - phase_start_ff;
   assign rc_age    = now_ms - last_rc_time_ff;

   assign s_hold = link_awake & port_open & serial_busy;
   assign h_hold = link_awake & hid_busy;
   assign d_hold = link_awake & data_waiting & ~moved;

   // A condition that starts holding on this poll has a held time of zero.
   assign s_time = (s_hold & serial_held_ff) ? now_ms - serial_since_ff : '0;
   assign h_time = (h_hold & hid_held_ff)    ? now_ms - hid_since_ff    : '0;
   assign d_time = (d_hold & data_held_ff)   ? now_ms - data_since_ff   : '0;

   assign any_stuck = (s_time >= {16'd0, cfg.stuck_limit_ms}) |
                      (h_time >= {16'd0, cfg.stuck_limit_ms}) |
                      (d_time >= {16'd0, cfg.stuck_limit_ms});
   assign too_soon  = (reconnects_ff != '0) & (rc_age < {16'd0, cfg.min_interval_ms});

   always_comb begin
      phase_in        = phase_ff;
      phase_start_in  = phase_start_ff;
      serial_held_in  = serial_held_ff;
      hid_held_in     = hid_held_ff;
      data_held_in    = data_held_ff;
      serial_since_in = serial_since_ff;
      hid_since_in    = hid_since_ff;
      data_since_in   = data_since_ff;
      reconnects_in   = reconnects_ff;
      last_rc_time_in = last_rc_time_ff;
      cfg_at_rc_in    = cfg_at_rc_ff;
      req_pend_in     = pend;
      go              = 1'b0;
      do_disconnect   = 1'b0;
      do_connect      = 1'b0;
      unique case (phase_ff)
         usw_pkg::PHASE_OFF: begin
            if (phase_age >= {16'd0, cfg.off_time_ms}) begin
               cfg_at_rc_in   = config_count;
               phase_in       = usw_pkg::PHASE_WAIT;
               phase_start_in = now_ms;
               do_connect     = 1'b1;
            end
         end
         usw_pkg::PHASE_WAIT: begin
            if ((config_count != cfg_at_rc_ff) ||
                (phase_age >= {16'd0, cfg.host_wait_ms})) begin
               phase_in = usw_pkg::PHASE_WATCH;
            end
         end
         default: begin
            // The unused phase code behaves as watching.
            if (s_hold && !serial_held_ff) serial_since_in = now_ms;
            if (h_hold && !hid_held_ff)    hid_since_in    = now_ms;
            if (d_hold && !data_held_ff)   data_since_in   = now_ms;
            go = pend | (any_stuck & ~too_soon);
            if (go) begin
               req_pend_in     = 1'b0;
               serial_held_in  = 1'b0;
               hid_held_in     = 1'b0;
               data_held_in    = 1'b0;
               reconnects_in   = reconnects_ff + 32'd1;
               last_rc_time_in = now_ms;
               phase_in        = usw_pkg::PHASE_OFF;
               phase_start_in  = now_ms;
               do_disconnect   = 1'b1;
            end else begin
               serial_held_in = s_hold;
               hid_held_in    = h_hold;
               data_held_in   = d_hold;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= usw_pkg::PHASE_WATCH;
         phase_start_ff  <= '0;
         serial_held_ff  <= 1'b0;
         hid_held_ff     <= 1'b0;
         data_held_ff    <= 1'b0;
         serial_since_ff <= '0;
         hid_since_ff    <= '0;
         data_since_ff   <= '0;
         last_bytes_ff   <= '0;
         reconnects_ff   <= '0;
         last_rc_time_ff <= '0;
         cfg_at_rc_ff    <= '0;
         req_pend_ff     <= 1'b0;
      end else if (commit) begin
         phase_ff        <= phase_in;
         phase_start_ff  <= phase_start_in;
         serial_held_ff  <= serial_held_in;
         hid_held_ff     <= hid_held_in;
         data_held_ff    <= data_held_in;
         serial_since_ff <= serial_since_in;
         hid_since_ff    <= hid_since_in;
         data_since_ff   <= data_since_in;
         last_bytes_ff   <= bytes_taken;
         reconnects_ff   <= reconnects_in;
         last_rc_time_ff <= last_rc_time_in;
         cfg_at_rc_ff    <= cfg_at_rc_in;
         req_pend_ff     <= req_pend_in;
      end
   end

   assign phase_now       = phase_in;
   assign reconnect_total = reconnects_in;

endmodule

FILE: rtl/usb_link_stall_watchdog_top.sv
// ----------------------------------------------------------------------------
// usb_link_stall_watchdog_top: USB link stall watchdog
// An accepted poll beat passes through the input register, then the result
// register. Throughput: one poll per cycle while rsp_stall does not hold the
// result register; the state update between the two registers is combinational.
// Reset is synchronous and active high; it restores the default timing
// settings and returns the watchdog to watching with all timers cleared.
// ----------------------------------------------------------------------------
module usb_link_stall_watchdog_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [31:0]                 req_now_ms,
   input  logic                        req_link_awake,
   input  logic                        req_port_open,
   input  logic                        req_serial_busy,
   input  logic                        req_hid_busy,
   input  logic                        req_data_waiting,
   input  logic [31:0]                 req_bytes_taken,
   input  logic [31:0]                 req_config_count,
   input  logic                        req_reconnect_request,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_do_disconnect,
   output logic                        rsp_do_connect,
   output logic [1:0]                  rsp_phase_now,
   output logic [31:0]                 rsp_reconnect_total,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [usw_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   usw_pkg::usw_cfg_type cfg;

   logic        in_vld_ff, in_vld_in;
   logic [31:0] now_ff, bytes_ff, cfgcnt_ff;
   logic        awake_ff, open_ff, sbusy_ff, hbusy_ff, dwait_ff, rreq_ff;
   logic        out_vld_ff, out_vld_in;
   logic        disc_ff, conn_ff;
   logic [1:0]  phase_ff;
   logic [31:0] total_ff;

   logic        out_free, advance, take;
   logic        disc_w, conn_w;
   logic [1:0]  phase_w;
   logic [31:0] total_w;

   usw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The result register frees up in the same cycle its beat is taken.
   assign out_free  = ~out_vld_ff | ~rsp_stall;
   assign advance   = in_vld_ff & out_free;
   assign req_stall = in_vld_ff & ~out_free;
   assign take      = req_valid & ~req_stall;

   assign in_vld_in  = take | (in_vld_ff & ~advance);
   assign out_vld_in = advance | (out_vld_ff & rsp_stall);

   usw_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .commit            (advance),
      .now_ms            (now_ff),
      .link_awake        (awake_ff),
      .port_open         (open_ff),
      .serial_busy       (sbusy_ff),
      .hid_busy          (hbusy_ff),
      .data_waiting      (dwait_ff),
      .bytes_taken       (bytes_ff),
      .config_count      (cfgcnt_ff),
      .reconnect_request (rreq_ff),
      .do_disconnect     (disc_w),
      .do_connect        (conn_w),
      .phase_now         (phase_w),
      .reconnect_total   (total_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         now_ff    <= req_now_ms;
         awake_ff  <= req_link_awake;
         open_ff   <= req_port_open;
         sbusy_ff  <= req_serial_busy;
         hbusy_ff  <= req_hid_busy;
         dwait_ff  <= req_data_waiting;
         bytes_ff  <= req_bytes_taken;
         cfgcnt_ff <= req_config_count;
         rreq_ff   <= req_reconnect_request;
      end
      if (advance) begin
         disc_ff  <= disc_w;
         conn_ff  <= conn_w;
         phase_ff <= phase_w;
         total_ff <= total_w;
      end
   end

   assign rsp_valid           = out_vld_ff;
   assign rsp_do_disconnect   = disc_ff;
   assign rsp_do_connect      = conn_ff;
   assign rsp_phase_now       = phase_ff;
   assign rsp_reconnect_total = total_ff;

endmodule
